@@ rtl/core/cbs_pkg.sv @@
`timescale 1ns / 1ps

package cbs_pkg;

   // Input item modes
   localparam logic [1:0] MODE_DATA  = 2'd0;
   localparam logic [1:0] MODE_END   = 2'd1;
   localparam logic [1:0] MODE_REPLY = 2'd2;
   localparam logic [1:0] MODE_SLOT  = 2'd3;

   // Result status codes
   localparam logic [1:0] STATUS_RUNNING   = 2'd0;
   localparam logic [1:0] STATUS_DONE      = 2'd1;
   localparam logic [1:0] STATUS_CANCELLED = 2'd2;
   localparam logic [1:0] STATUS_ERROR     = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_ACK    = 2'd0;
   localparam logic [1:0] CSR_NAK    = 2'd1;
   localparam logic [1:0] CSR_CANCEL = 2'd2;

   // Configuration reset values
   localparam logic [7:0] ACK_RESET    = 8'd6;
   localparam logic [7:0] NAK_RESET    = 8'd21;
   localparam logic [7:0] CANCEL_RESET = 8'd24;

   // Check byte modulus
   localparam logic [8:0] CHECK_MOD = 9'd255;

   typedef enum logic [5:0] {
      PH_FILLING   = 6'b000001,
      PH_SENDING   = 6'b000010,
      PH_WAITING   = 6'b000100,
      PH_DONE      = 6'b001000,
      PH_CANCELLED = 6'b010000,
      PH_ERROR     = 6'b100000
   } phase_type;

   // One processed item on its way to the result register
   typedef struct packed {
      logic       valid;
      logic       tx_valid;
      logic       from_ram;
      logic [7:0] tx_byte;
      logic       accepted;
      logic [1:0] status;
   } stage_type;

   function automatic logic [1:0] status_of(input phase_type ph);
      logic [1:0] st;
      case (ph)
         PH_DONE:      st = STATUS_DONE;
         PH_CANCELLED: st = STATUS_CANCELLED;
         PH_ERROR:     st = STATUS_ERROR;
         default:      st = STATUS_RUNNING;
      endcase
      return st;
   endfunction

endpackage

@@ rtl/core/cbs_ram.sv @@
`timescale 1ns / 1ps

module cbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 127
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/cbs_ctrl.sv @@
`timescale 1ns / 1ps

module cbs_ctrl #(
   parameter int BLOCK_BYTES = 127
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          mode,
   input  logic [7:0]          data_byte,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_wdata,
   input  logic                stage_take,
   output cbs_pkg::stage_type  stage,
   output logic [7:0]          rd_data
);

   localparam int CNT_W  = $clog2(BLOCK_BYTES + 1);
   localparam int ADDR_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
   localparam logic [CNT_W-1:0] LAST = CNT_W'(BLOCK_BYTES);

   cbs_pkg::phase_type phase_ff, phase_in;
   logic [CNT_W-1:0]   fill_ff, fill_in, fill_inc;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic [7:0]         check_ff, check_in, check_next;
   logic [8:0]         check_sum;
   logic               final_ff, final_in;
   logic [7:0]         ack_ff, nak_ff, cancel_ff;
   logic               ram_we, ram_re;
   cbs_pkg::stage_type stage_ff, stage_in, item;

   // Configuration writes; unknown indexes do nothing
   always_ff @(posedge clock) begin
      if (reset) begin
         ack_ff    <= cbs_pkg::ACK_RESET;
         nak_ff    <= cbs_pkg::NAK_RESET;
         cancel_ff <= cbs_pkg::CANCEL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            cbs_pkg::CSR_ACK:    ack_ff    <= csr_wdata;
            cbs_pkg::CSR_NAK:    nak_ff    <= csr_wdata;
            cbs_pkg::CSR_CANCEL: cancel_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Running check modulo 255: the sum stays below twice the modulus
   assign check_sum  = {1'b0, check_ff} + {1'b0, data_byte};
   assign check_next = (check_sum >= cbs_pkg::CHECK_MOD) ?
                       8'(check_sum - cbs_pkg::CHECK_MOD) : check_sum[7:0];
   assign fill_inc   = fill_ff + CNT_W'(1);

   // Step the sender for one accepted transfer
   always_comb begin
      phase_in = phase_ff;
      fill_in  = fill_ff;
      pos_in   = pos_ff;
      check_in = check_ff;
      final_in = final_ff;
      ram_we   = 1'b0;
      ram_re   = 1'b0;
      item     = '0;
      if (accept) begin
         item.valid = 1'b1;
         case (mode)
            cbs_pkg::MODE_DATA: begin
               if (phase_ff == cbs_pkg::PH_FILLING && fill_ff < LAST) begin
                  ram_we        = 1'b1;
                  fill_in       = fill_inc;
                  check_in      = check_next;
                  item.accepted = 1'b1;
                  if (fill_inc >= LAST) begin
                     phase_in = cbs_pkg::PH_SENDING;
                     pos_in   = '0;
                  end
               end
            end
            cbs_pkg::MODE_END: begin
               if (phase_ff == cbs_pkg::PH_FILLING) begin
                  final_in = 1'b1;
                  if (fill_ff == '0) begin
                     phase_in = cbs_pkg::PH_DONE;
                  end else begin
                     phase_in = cbs_pkg::PH_SENDING;
                     pos_in   = '0;
                  end
               end else if (phase_ff == cbs_pkg::PH_SENDING ||
                            phase_ff == cbs_pkg::PH_WAITING) begin
                  final_in = 1'b1;
               end
            end
            cbs_pkg::MODE_REPLY: begin
               if (phase_ff == cbs_pkg::PH_WAITING) begin
                  if (data_byte == cancel_ff) begin
                     phase_in = cbs_pkg::PH_CANCELLED;
                  end else if (data_byte == ack_ff) begin
                     fill_in  = '0;
                     check_in = '0;
                     pos_in   = '0;
                     phase_in = final_ff ? cbs_pkg::PH_DONE : cbs_pkg::PH_FILLING;
                  end else if (data_byte == nak_ff) begin
                     phase_in = cbs_pkg::PH_SENDING;
                     pos_in   = '0;
                  end else begin
                     phase_in = cbs_pkg::PH_ERROR;
                  end
               end
            end
            cbs_pkg::MODE_SLOT: begin
               if (phase_ff == cbs_pkg::PH_SENDING) begin
                  item.tx_valid = 1'b1;
                  if (pos_ff < LAST) begin
                     if (pos_ff < fill_ff) begin
                        ram_re        = 1'b1;
                        item.from_ram = 1'b1;
                     end
                     pos_in = pos_ff + CNT_W'(1);
                  end else begin
                     item.tx_byte = check_ff;
                     phase_in     = cbs_pkg::PH_WAITING;
                  end
               end
            end
            default: ;
         endcase
         item.status = cbs_pkg::status_of(phase_in);
      end
   end

   // Hold the item until the result register takes it
   always_comb begin
      if (accept) begin
         stage_in = item;
      end else if (stage_take) begin
         stage_in = '0;
      end else begin
         stage_in = stage_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cbs_pkg::PH_FILLING;
         fill_ff  <= '0;
         pos_ff   <= '0;
         check_ff <= '0;
         final_ff <= 1'b0;
         stage_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         fill_ff  <= fill_in;
         pos_ff   <= pos_in;
         check_ff <= check_in;
         final_ff <= final_in;
         stage_ff <= stage_in;
      end
   end

   assign stage = stage_ff;

   cbs_ram #(
      .WIDTH (8),
      .DEPTH (BLOCK_BYTES)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (data_byte),
      .rd_en   (ram_re),
      .rd_addr (pos_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Counters never pass the block size
   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LAST && pos_ff <= LAST)
      else $error("fill or send position beyond block size");

   // Slot at the check byte moves to waiting
   a_check_to_wait: assert property (@(posedge clock) disable iff (reset)
      accept && mode == cbs_pkg::MODE_SLOT && phase_ff == cbs_pkg::PH_SENDING &&
      pos_ff == LAST |=> phase_ff == cbs_pkg::PH_WAITING)
      else $error("check byte did not end the frame");

   // Terminal phases hold
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      phase_ff == cbs_pkg::PH_DONE || phase_ff == cbs_pkg::PH_CANCELLED ||
      phase_ff == cbs_pkg::PH_ERROR |=> $stable(phase_ff))
      else $error("terminal phase left");

endmodule

@@ rtl/core/cbs_out.sv @@
`timescale 1ns / 1ps

module cbs_out (
   input  logic               clock,
   input  logic               reset,
   input  cbs_pkg::stage_type stage,
   input  logic [7:0]         rd_data,
   output logic               stage_take,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_tx_valid,
   output logic [7:0]         rsp_tx_byte,
   output logic               rsp_accepted,
   output logic [1:0]         rsp_status
);

   logic       valid_ff, valid_in;
   logic       tx_valid_ff;
   logic [7:0] tx_byte_ff;
   logic       accepted_ff;
   logic [1:0] status_ff;

   // Load when the result register is empty or being drained
   assign stage_take = !valid_ff || !rsp_stall;
   assign valid_in   = stage_take ? stage.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Merge buffer read data into the result
   always_ff @(posedge clock) begin
      if (stage_take && stage.valid) begin
         tx_valid_ff <= stage.tx_valid;
         tx_byte_ff  <= stage.from_ram ? rd_data : stage.tx_byte;
         accepted_ff <= stage.accepted;
         status_ff   <= stage.status;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_tx_valid = tx_valid_ff;
   assign rsp_tx_byte  = tx_byte_ff;
   assign rsp_accepted = accepted_ff;
   assign rsp_status   = status_ff;

   // A waiting item reaches the result register when it is free
   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      stage.valid && stage_take |=> valid_ff)
      else $error("taken item lost");

endmodule

@@ rtl/core/checked_block_sender_with_ack_top.sv @@
`timescale 1ns / 1ps
// Path: an item transferred in moves through the stage register to the result
// register, where it can transfer out. Throughput: one input transfer per cycle
// while the output does not stall; the block buffer memory takes a write or a
// read each cycle, and the result register drains while the next item enters.
// Reset: synchronous, active high; clears phase, counters, check and registers
// to their defaults and stalls the input. The block buffer is not cleared.

module checked_block_sender_with_ack_top #(
   parameter int BLOCK_BYTES = 127
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_accepted,
   output logic [1:0] rsp_status,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   cbs_pkg::stage_type stage;
   logic [7:0]         rd_data;
   logic               stage_take;
   logic               accept;

   // Stall during reset and while the processed item cannot move on
   assign req_stall = reset || (stage.valid && !stage_take);
   assign accept    = req_valid && !req_stall;

   cbs_ctrl #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .mode       (req_mode),
      .data_byte  (req_data_byte),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .stage_take (stage_take),
      .stage      (stage),
      .rd_data    (rd_data)
   );

   cbs_out u_out (
      .clock        (clock),
      .reset        (reset),
      .stage        (stage),
      .rd_data      (rd_data),
      .stage_take   (stage_take),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_tx_valid (rsp_tx_valid),
      .rsp_tx_byte  (rsp_tx_byte),
      .rsp_accepted (rsp_accepted),
      .rsp_status   (rsp_status)
   );

endmodule
